FILE: rtl/log_domain_bass_compressor_macros.svh
// ----------------------------------------------------------------------------
// log_domain_bass_compressor_macros.svh
// Assertion macros used by the compressor top level.
// ----------------------------------------------------------------------------
`ifndef LOG_DOMAIN_BASS_COMPRESSOR_MACROS_SVH
`define LOG_DOMAIN_BASS_COMPRESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Types, constants and helpers of the log-domain bass compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  // Widest supported sample; queue entries are sized for it
  localparam int MAG_W = 24;
  localparam int AW    = 34;   // accumulator / multiplier A width
  localparam int BW    = 28;   // multiplier B width
  localparam int PW    = AW + BW;

  // log2 cubic, Q24
  localparam logic signed [AW-1:0] LC0 = 34'sd20661073;
  localparam logic signed [AW-1:0] LC1 = -34'sd69097386;
  localparam logic signed [AW-1:0] LC2 = 34'sd101031894;
  localparam logic signed [AW-1:0] LC3 = -34'sd52579199;
  // 20/log2(10) and its inverse
  localparam logic signed [BW-1:0] DB_PER_LOG2   = 28'sd101008905;
  localparam logic signed [BW-1:0] LOG2_PER_DB20 = 28'sd2786635;
  // 2^x cubic, Q24
  localparam logic signed [AW-1:0] EC1 = 34'sd11663162;
  localparam logic signed [AW-1:0] EC2 = 34'sd3794048;
  localparam logic signed [AW-1:0] EC3 = 34'sd1320006;
  localparam logic signed [AW-1:0] ONE_Q24 = 34'sd16777216;
  // ceil(2^23/5), exact floor(n/5) for n < 2^20
  localparam logic signed [BW-1:0] RECIP5 = 28'sd1677722;

  // Register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_ATTACK    = 3'd1;
  localparam logic [2:0] REG_RELEASE   = 3'd2;
  localparam logic [2:0] REG_RATIO     = 3'd3;
  localparam logic [2:0] REG_POS_SCALE = 3'd4;
  localparam logic [2:0] REG_NEG_SCALE = 3'd5;
  localparam logic [2:0] REG_VOLUME    = 3'd6;

  // Reset values
  localparam logic signed [15:0] RST_THRESHOLD = -16'sd16640;
  localparam logic [23:0] RST_ATTACK    = 24'd16775471;
  localparam logic [23:0] RST_RELEASE   = 24'd15113621;
  localparam logic [15:0] RST_RATIO     = 16'd13107;
  localparam logic [15:0] RST_POS_SCALE = 16'd19661;
  localparam logic [15:0] RST_NEG_SCALE = 16'd13107;
  localparam logic [15:0] RST_VOLUME    = 16'd21725;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [23:0]        attack_coef;
    logic [23:0]        release_coef;
    logic [15:0]        ratio_term;
    logic [15:0]        positive_scale;
    logic [15:0]        negative_scale;
    logic [15:0]        output_volume;
  } cfg_t;

  // One classified sample
  typedef struct packed {
    logic              neg;
    logic              pos;
    logic              zero;
    logic              last;
    logic [MAG_W-1:0]  mag;
    logic [23:0]       f24;
    logic signed [6:0] e;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P1M, ST_P1A, ST_P2M, ST_P2A, ST_P3M, ST_P3A,
    ST_LVM, ST_LVA, ST_EM1, ST_EM2, ST_EA, ST_DVM, ST_DVA,
    ST_FM, ST_FA, ST_GM, ST_GA, ST_XM, ST_XA,
    ST_Q1M, ST_Q1A, ST_Q2M, ST_Q2A, ST_Q3M, ST_Q3A,
    ST_VM, ST_MM, ST_OUT
  } st_t;

  // Round half up, then arithmetic shift
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] v,
                                                    input logic [5:0] sh);
    logic signed [PW-1:0] bias;
    bias = 62'sd1 <<< (sh - 6'd1);
    return (v + bias) >>> sh;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/log_domain_bass_compressor.sv
// The sequencer takes one sample at a time from the queue and steps through its
// products on its single shared multiplier, plus load and output steps; it takes
// no new sample until the result is in the output register.
// The two-entry queue accepts input while the sequencer works.
// Reset (rst_n low, synchronous) clears the envelope, queue and output valid
// and loads the register defaults.
// ----------------------------------------------------------------------------
// log_domain_bass_compressor
// Log-domain compressor: dB level, envelope follower, gain, saturated output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_domain_bass_compressor_macros.svh"

module log_domain_bass_compressor
  import lbc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: [SAMPLE_BITS-1:0] sample_in, rest zero
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                in_tlast,   // block_last
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata: [SAMPLE_BITS-1:0] sample_out, rest zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,
  output logic                                     out_tlast,  // block_last_out
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [23:0]                         cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cfg_t                   cfg_r, cfg_nxt;
  item_t                  f_item, q_item;
  logic                   q_push, q_full, q_pop, q_valid;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;
  assign out_tdata = TDATA_W'(out_sample);

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_nxt.threshold_db   = cfg_data[15:0];
        REG_ATTACK:    cfg_nxt.attack_coef    = cfg_data;
        REG_RELEASE:   cfg_nxt.release_coef   = cfg_data;
        REG_RATIO:     cfg_nxt.ratio_term     = cfg_data[15:0];
        REG_POS_SCALE: cfg_nxt.positive_scale = cfg_data[15:0];
        REG_NEG_SCALE: cfg_nxt.negative_scale = cfg_data[15:0];
        REG_VOLUME:    cfg_nxt.output_volume  = cfg_data[15:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db   <= RST_THRESHOLD;
      cfg_r.attack_coef    <= RST_ATTACK;
      cfg_r.release_coef   <= RST_RELEASE;
      cfg_r.ratio_term     <= RST_RATIO;
      cfg_r.positive_scale <= RST_POS_SCALE;
      cfg_r.negative_scale <= RST_NEG_SCALE;
      cfg_r.output_volume  <= RST_VOLUME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lbc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item)
  );

  lbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  lbc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (out_sample),
    .out_tlast  (out_tlast)
  );

  // Checks
  `LBC_ASSERT_NEXT(a_push_lands, in_tvalid && in_tready, q_valid, "accepted sample not queued")
  `LBC_ASSERT_NOW(a_pop_has_data, q_pop, q_valid, "sequencer popped an empty queue")
  `LBC_ASSERT_NOW(a_empty_accepts, !q_valid, in_tready, "empty queue refused input")

endmodule

`default_nettype wire

FILE: rtl/lbc_front.sv
// ----------------------------------------------------------------------------
// lbc_front
// Input side: takes a sample, splits magnitude into mantissa and exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_front
  import lbc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   in_tlast,
  input  wire logic                   q_full,
  output logic                        q_push,
  output item_t                       q_item
);

  logic [SAMPLE_BITS-1:0] mag_w;
  logic [MAG_W-1:0]       mag_ext;
  logic [4:0]             lead_w;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Magnitude and leading-one position
  always_comb begin
    mag_w = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    lead_w = '0;
    for (int b = 0; b < SAMPLE_BITS; b++) begin
      if (mag_w[b]) begin
        lead_w = 5'(b);
      end
    end
    mag_ext = MAG_W'(mag_w);
  end

  // Classified transaction
  always_comb begin
    q_item.neg  = sample[SAMPLE_BITS-1];
    q_item.zero = (mag_w == '0);
    q_item.pos  = !sample[SAMPLE_BITS-1] && (mag_w != '0);
    q_item.last = in_tlast;
    q_item.mag  = mag_ext;
    q_item.f24  = 24'(mag_ext << (5'd23 - lead_w));
    q_item.e    = 7'({2'b00, lead_w}) + 7'd2 - 7'(SAMPLE_BITS);
  end

endmodule

`default_nettype wire

FILE: rtl/lbc_queue.sv
// ----------------------------------------------------------------------------
// lbc_queue
// Two-entry queue between the front and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_queue
  import lbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output item_t      pop_item
);

  item_t      slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_item = slot_r[rptr_r];

  // Pointer and fill count
  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lbc_back.sv
// ----------------------------------------------------------------------------
// lbc_back
// Sequencer with one shared multiplier: level, envelope, gain, output.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_back
  import lbc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cfg_t                    cfg,
  input  wire logic                    q_valid,
  input  wire item_t                   q_item,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [SAMPLE_BITS-1:0]       out_sample,
  output logic                         out_tlast
);

  st_t                    state_r, state_nxt;
  item_t                  item_r, item_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic signed [PW-1:0]   pr_r;
  logic [57:0]            sum_r, sum_nxt;
  logic [31:0]            env_r, env_nxt;
  logic [23:0]            c_r, c_nxt;
  logic [15:0]            delta_r, delta_nxt;
  logic signed [11:0]     ip_r, ip_nxt;
  logic [23:0]            fr_r, fr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_last_r, out_last_nxt;

  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   mul_en;
  logic signed [AW-1:0]   rnd24_w, rnd14_w;
  logic signed [19:0]     level_w;
  logic signed [20:0]     diff_w;
  logic [31:0]            d32_w;
  logic [19:0]            n5_w;
  logic [16:0]            q5_w;
  logic [57:0]            prod_w;
  logic [SAMPLE_BITS-1:0] lim_w, r_w, y_w;
  logic [11:0]            k_up, k_dn;
  logic [63:0]            t64_w;
  logic                   sat_w;

  assign mul_p      = mul_a * mul_b;
  assign rnd24_w    = AW'(rnd_shr(pr_r, 6'd24));
  assign rnd14_w    = AW'(rnd_shr(pr_r, 6'd14));
  assign level_w    = 20'(rnd_shr(pr_r, 6'd40));
  assign diff_w     = 21'(level_w) - 21'(cfg.threshold_db);
  assign d32_w      = {delta_r, 16'h0000};
  assign n5_w       = {1'b0, delta_r, 3'b000} + 20'd2;
  assign q5_w       = 17'(pr_r >>> 23);
  assign prod_w     = pr_r[57:0];
  assign out_tvalid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_tlast  = out_last_r;

  // Final scaling by 2^(ip-32), rounding, saturation, sign
  always_comb begin
    lim_w = item_r.neg ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    k_up  = 12'(ip_r - 12'sd32);
    k_dn  = 12'(12'sd32 - ip_r);
    t64_w = '0;
    sat_w = 1'b0;
    if (ip_r >= 12'sd32) begin
      sat_w = (k_up >= 12'd40) || (prod_w > (58'(lim_w) >> k_up));
      r_w   = sat_w ? lim_w : SAMPLE_BITS'(prod_w << k_up);
    end else if (k_dn >= 12'd63) begin
      r_w = '0;
    end else begin
      t64_w = ({6'b000000, prod_w} + (64'd1 << (k_dn - 12'd1))) >> k_dn;
      r_w   = (t64_w > 64'(lim_w)) ? lim_w : SAMPLE_BITS'(t64_w);
    end
    if (item_r.zero) begin
      y_w = '0;
    end else begin
      y_w = item_r.neg ? (~r_w + 1'b1) : r_w;
    end
  end

  // Sequencer: multiply states load pr_r, add states consume it
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    acc_nxt        = acc_r;
    sum_nxt        = sum_r;
    env_nxt        = env_r;
    c_nxt          = c_r;
    delta_nxt      = delta_r;
    ip_nxt         = ip_r;
    fr_nxt         = fr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    mul_a          = '0;
    mul_b          = '0;
    mul_en         = 1'b0;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          acc_nxt   = LC0;
          state_nxt = ST_P1M;
        end
      end
      // log2 cubic
      ST_P1M: begin
        mul_a = acc_r; mul_b = {4'b0000, item_r.f24}; mul_en = 1'b1;
        state_nxt = ST_P1A;
      end
      ST_P1A: begin
        acc_nxt = rnd24_w + LC1; state_nxt = ST_P2M;
      end
      ST_P2M: begin
        mul_a = acc_r; mul_b = {4'b0000, item_r.f24}; mul_en = 1'b1;
        state_nxt = ST_P2A;
      end
      ST_P2A: begin
        acc_nxt = rnd24_w + LC2; state_nxt = ST_P3M;
      end
      ST_P3M: begin
        mul_a = acc_r; mul_b = {4'b0000, item_r.f24}; mul_en = 1'b1;
        state_nxt = ST_P3A;
      end
      ST_P3A: begin
        acc_nxt = rnd24_w + LC3 + ({{(AW-7){item_r.e[6]}}, item_r.e} <<< 24);
        state_nxt = ST_LVM;
      end
      // level in dB, excess over threshold
      ST_LVM: begin
        mul_a = acc_r; mul_b = DB_PER_LOG2; mul_en = 1'b1;
        state_nxt = ST_LVA;
      end
      ST_LVA: begin
        if (item_r.zero || diff_w <= 21'sd0) begin
          delta_nxt = '0;
        end else if (diff_w > 21'sd65535) begin
          delta_nxt = 16'hFFFF;
        end else begin
          delta_nxt = diff_w[15:0];
        end
        state_nxt = ST_EM1;
      end
      // envelope follower
      ST_EM1: begin
        c_nxt  = (d32_w > env_r) ? cfg.attack_coef : cfg.release_coef;
        mul_a  = {2'b00, env_r};
        mul_b  = {4'b0000, c_nxt};
        mul_en = 1'b1;
        state_nxt = ST_EM2;
      end
      ST_EM2: begin
        sum_nxt = prod_w;
        mul_a   = {2'b00, d32_w};
        mul_b   = {3'b000, 25'h1000000 - {1'b0, c_r}};
        mul_en  = 1'b1;
        state_nxt = ST_EA;
      end
      ST_EA: begin
        env_nxt = 32'((sum_r + prod_w + 58'd8388608) >> 24);
        state_nxt = ST_DVM;
      end
      // ratio term minus excess/160 (as (8d+2)/5)
      ST_DVM: begin
        mul_a = {14'b0, n5_w}; mul_b = RECIP5; mul_en = 1'b1;
        state_nxt = ST_DVA;
      end
      ST_DVA: begin
        acc_nxt = {18'b0, cfg.ratio_term} - {17'b0, q5_w};
        state_nxt = ST_FM;
      end
      ST_FM: begin
        mul_a = {2'b00, env_r}; mul_b = BW'(acc_r); mul_en = 1'b1;
        state_nxt = ST_FA;
      end
      ST_FA: begin
        acc_nxt = rnd24_w; state_nxt = ST_GM;
      end
      ST_GM: begin
        mul_a  = acc_r;
        mul_b  = {12'b0, item_r.pos ? cfg.positive_scale : cfg.negative_scale};
        mul_en = 1'b1;
        state_nxt = ST_GA;
      end
      ST_GA: begin
        acc_nxt = rnd14_w; state_nxt = ST_XM;
      end
      // gain dB to log2 exponent, split integer and fraction
      ST_XM: begin
        mul_a = acc_r; mul_b = LOG2_PER_DB20; mul_en = 1'b1;
        state_nxt = ST_XA;
      end
      ST_XA: begin
        ip_nxt  = 12'(rnd24_w >>> 16);
        fr_nxt  = {rnd24_w[15:0], 8'h00};
        acc_nxt = EC3;
        state_nxt = ST_Q1M;
      end
      // 2^fraction cubic
      ST_Q1M: begin
        mul_a = acc_r; mul_b = {4'b0000, fr_r}; mul_en = 1'b1;
        state_nxt = ST_Q1A;
      end
      ST_Q1A: begin
        acc_nxt = rnd24_w + EC2; state_nxt = ST_Q2M;
      end
      ST_Q2M: begin
        mul_a = acc_r; mul_b = {4'b0000, fr_r}; mul_en = 1'b1;
        state_nxt = ST_Q2A;
      end
      ST_Q2A: begin
        acc_nxt = rnd24_w + EC1; state_nxt = ST_Q3M;
      end
      ST_Q3M: begin
        mul_a = acc_r; mul_b = {4'b0000, fr_r}; mul_en = 1'b1;
        state_nxt = ST_Q3A;
      end
      ST_Q3A: begin
        acc_nxt = rnd24_w + ONE_Q24; state_nxt = ST_VM;
      end
      // volume times mantissa, then times magnitude
      ST_VM: begin
        mul_a = acc_r >>> 8; mul_b = {12'b0, cfg.output_volume}; mul_en = 1'b1;
        state_nxt = ST_MM;
      end
      ST_MM: begin
        mul_a = pr_r[AW-1:0]; mul_b = {4'b0000, item_r.mag}; mul_en = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_w;
          out_last_nxt   = item_r.last;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    acc_r        <= acc_nxt;
    sum_r        <= sum_nxt;
    c_r          <= c_nxt;
    delta_r      <= delta_nxt;
    ip_r         <= ip_nxt;
    fr_r         <= fr_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
    if (mul_en) begin
      pr_r <= mul_p;
    end
  end

endmodule

`default_nettype wire
